// ----- rtl/core/qstm_pkg.sv -----
`default_nettype none
package qstm_pkg;

  // field widths
  localparam int QW   = 16;  // quaternion and scale components
  localparam int TW   = 32;  // translation
  localparam int OW   = 32;  // matrix entries
  localparam int PW   = 32;  // component products
  localparam int NW   = 33;  // squared norm, unsigned
  localparam int SNW  = 34;  // signed numerator terms N[i][j]
  localparam int MAGW = 48;  // |scale| * |N|
  localparam int DW   = 58;  // rounded dividend 2*256*|S*N| + n
  localparam int QB   = 24;  // quotient bits, |entry| <= 2^23
  localparam int RW   = 34;  // partial remainder, below divisor 2n
  localparam int LANES = 9;

  // divider pipeline shape
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = QB / STEPS_PER_STAGE;

  // one matrix entry in flight through the divider
  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QB-1:0] lo;   // dividend bits still to consume, quotient bits shifted in
    logic          neg;
  } qstm_lane_t;

  // one restoring division step
  function automatic qstm_lane_t div_step(qstm_lane_t a, logic [RW-1:0] d);
    logic [RW:0] t;
    logic        ge;
    qstm_lane_t  r;
    t  = {a.rem, a.lo[QB-1]};
    ge = (t >= {1'b0, d});
    r  = a;
    r.rem = ge ? RW'(t - {1'b0, d}) : t[RW-1:0];
    r.lo  = {a.lo[QB-2:0], ge};
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/quaternion_scale_translate_to_matrix_top.sv -----
// Quaternion, per-row scale and translation to the rows of an affine transform.
// Pulse start with a request on the in_ ports; busy is always low, so a request
// may be issued every cycle. Each result appears for exactly one cycle with
// out_strobe high; the receiver cannot stall and must take it then. Each entry
// is an exact rounding division by the squared quaternion norm: nine lanes of a
// restoring divider resolve two quotient bits per stage over twelve stages,
// after six stages of input, products, sums, magnitudes, scale multiply and
// dividend setup, plus the output register. An all-zero quaternion yields the
// identity rotation scaled per row.
`default_nettype none
module quaternion_scale_translate_to_matrix_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  signed [qstm_pkg::QW-1:0] in_quat_x,
  input  wire  signed [qstm_pkg::QW-1:0] in_quat_y,
  input  wire  signed [qstm_pkg::QW-1:0] in_quat_z,
  input  wire  signed [qstm_pkg::QW-1:0] in_quat_w,
  input  wire  signed [qstm_pkg::QW-1:0] in_scale_x,
  input  wire  signed [qstm_pkg::QW-1:0] in_scale_y,
  input  wire  signed [qstm_pkg::QW-1:0] in_scale_z,
  input  wire  signed [qstm_pkg::TW-1:0] in_trans_x,
  input  wire  signed [qstm_pkg::TW-1:0] in_trans_y,
  input  wire  signed [qstm_pkg::TW-1:0] in_trans_z,
  output logic                         out_strobe,
  output logic signed [qstm_pkg::OW-1:0] out_m00,
  output logic signed [qstm_pkg::OW-1:0] out_m01,
  output logic signed [qstm_pkg::OW-1:0] out_m02,
  output logic signed [qstm_pkg::OW-1:0] out_m10,
  output logic signed [qstm_pkg::OW-1:0] out_m11,
  output logic signed [qstm_pkg::OW-1:0] out_m12,
  output logic signed [qstm_pkg::OW-1:0] out_m20,
  output logic signed [qstm_pkg::OW-1:0] out_m21,
  output logic signed [qstm_pkg::OW-1:0] out_m22,
  output logic signed [qstm_pkg::TW-1:0] out_tx,
  output logic signed [qstm_pkg::TW-1:0] out_ty,
  output logic signed [qstm_pkg::TW-1:0] out_tz
);
  import qstm_pkg::*;

  logic accept;

  // stage 0: input register
  logic                 v0_r;
  logic signed [QW-1:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [QW-1:0] sc0_r [0:2];
  logic signed [TW-1:0] tr0_r [0:2];

  // stage 1: component products
  logic                 v1_r;
  logic signed [PW-1:0] pxx_r, pyy_r, pzz_r, pww_r;
  logic signed [PW-1:0] pxy_r, pzw_r, pxz_r, pyw_r, pyz_r, pxw_r;
  logic signed [QW-1:0] sc1_r [0:2];
  logic signed [TW-1:0] tr1_r [0:2];

  // stage 2: norm and numerators
  logic                  v2_r;
  logic [NW-1:0]         n2_r;
  logic signed [SNW-1:0] nn2_r [0:LANES-1];
  logic signed [QW-1:0]  sc2_r [0:2];
  logic signed [TW-1:0]  tr2_r [0:2];
  logic signed [SNW-1:0] xx_e, yy_e, zz_e, ww_e, xy_e, zw_e, xz_e, yw_e, yz_e, xw_e;

  // stage 3: magnitudes and signs
  logic                 v3_r;
  logic [NW-1:0]        n3_r;
  logic                 zero3_r;
  logic [NW-1:0]        nabs3_r [0:LANES-1];
  logic                 neg3_r  [0:LANES-1];
  logic [QW-1:0]        sabs3_r [0:2];
  logic signed [QW-1:0] sc3_r   [0:2];
  logic signed [TW-1:0] tr3_r   [0:2];

  // stage 4: scale multiply
  logic                 v4_r;
  logic [NW-1:0]        n4_r;
  logic                 zero4_r;
  logic [MAGW-1:0]      mag4_r [0:LANES-1];
  logic                 neg4_r [0:LANES-1];
  logic signed [QW-1:0] sc4_r  [0:2];
  logic signed [TW-1:0] tr4_r  [0:2];

  // divider stages: index 0 holds the dividend setup
  logic                 dv_r   [0:DIV_STAGES];
  logic [RW-1:0]        dvs_r  [0:DIV_STAGES];
  logic                 dz_r   [0:DIV_STAGES];
  qstm_lane_t           lane_r [0:DIV_STAGES][0:LANES-1];
  logic signed [QW-1:0] dsc_r  [0:DIV_STAGES][0:2];
  logic signed [TW-1:0] dtr_r  [0:DIV_STAGES][0:2];

  // output stage
  logic                 vo_r;
  logic                 zo_r;
  logic signed [OW-1:0] mo_r [0:LANES-1];
  logic signed [TW-1:0] to_r [0:2];

  // the pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // hold valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) dv_r[k] <= 1'b0;
    end else begin
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      dv_r[0] <= v4_r;
      for (int k = 1; k <= DIV_STAGES; k++) dv_r[k] <= dv_r[k-1];
      vo_r <= dv_r[DIV_STAGES];
    end
  end

  // capture request
  always_ff @(posedge clk) begin
    qx_r <= in_quat_x;
    qy_r <= in_quat_y;
    qz_r <= in_quat_z;
    qw_r <= in_quat_w;
    sc0_r[0] <= in_scale_x;
    sc0_r[1] <= in_scale_y;
    sc0_r[2] <= in_scale_z;
    tr0_r[0] <= in_trans_x;
    tr0_r[1] <= in_trans_y;
    tr0_r[2] <= in_trans_z;
  end

  // form component products
  always_ff @(posedge clk) begin
    pxx_r <= qx_r * qx_r;
    pyy_r <= qy_r * qy_r;
    pzz_r <= qz_r * qz_r;
    pww_r <= qw_r * qw_r;
    pxy_r <= qx_r * qy_r;
    pzw_r <= qz_r * qw_r;
    pxz_r <= qx_r * qz_r;
    pyw_r <= qy_r * qw_r;
    pyz_r <= qy_r * qz_r;
    pxw_r <= qx_r * qw_r;
    sc1_r <= sc0_r;
    tr1_r <= tr0_r;
  end

  assign xx_e = SNW'(pxx_r);
  assign yy_e = SNW'(pyy_r);
  assign zz_e = SNW'(pzz_r);
  assign ww_e = SNW'(pww_r);
  assign xy_e = SNW'(pxy_r);
  assign zw_e = SNW'(pzw_r);
  assign xz_e = SNW'(pxz_r);
  assign yw_e = SNW'(pyw_r);
  assign yz_e = SNW'(pyz_r);
  assign xw_e = SNW'(pxw_r);

  // sum norm and numerators; diagonal uses n - 2(a+b) = the other two minus a, b
  always_ff @(posedge clk) begin
    n2_r     <= NW'(xx_e + yy_e + zz_e + ww_e);
    nn2_r[0] <= xx_e + ww_e - yy_e - zz_e;
    nn2_r[1] <= (xy_e - zw_e) <<< 1;
    nn2_r[2] <= (xz_e + yw_e) <<< 1;
    nn2_r[3] <= (xy_e + zw_e) <<< 1;
    nn2_r[4] <= yy_e + ww_e - xx_e - zz_e;
    nn2_r[5] <= (yz_e - xw_e) <<< 1;
    nn2_r[6] <= (xz_e - yw_e) <<< 1;
    nn2_r[7] <= (yz_e + xw_e) <<< 1;
    nn2_r[8] <= zz_e + ww_e - xx_e - yy_e;
    sc2_r <= sc1_r;
    tr2_r <= tr1_r;
  end

  // split magnitudes and signs
  always_ff @(posedge clk) begin
    n3_r    <= n2_r;
    zero3_r <= (n2_r == '0);
    for (int i = 0; i < LANES; i++) begin
      nabs3_r[i] <= nn2_r[i][SNW-1] ? NW'(-nn2_r[i]) : NW'(nn2_r[i]);
      neg3_r[i]  <= nn2_r[i][SNW-1] ^ sc2_r[i/3][QW-1];
    end
    for (int r = 0; r < 3; r++) begin
      sabs3_r[r] <= sc2_r[r][QW-1] ? QW'(-sc2_r[r]) : QW'(sc2_r[r]);
    end
    sc3_r <= sc2_r;
    tr3_r <= tr2_r;
  end

  // multiply by row scale
  always_ff @(posedge clk) begin
    n4_r    <= n3_r;
    zero4_r <= zero3_r;
    for (int i = 0; i < LANES; i++) begin
      mag4_r[i] <= MAGW'(sabs3_r[i/3] * nabs3_r[i]);
      neg4_r[i] <= neg3_r[i];
    end
    sc4_r <= sc3_r;
    tr4_r <= tr3_r;
  end

  // set up dividend 2*256*mag + n over divisor 2n, quotient rounds half away
  always_ff @(posedge clk) begin : div_setup
    logic [DW-1:0] dd;
    for (int i = 0; i < LANES; i++) begin
      dd = {1'b0, mag4_r[i], 9'h000} + DW'(n4_r);
      lane_r[0][i].rem <= dd[DW-1:QB];
      lane_r[0][i].lo  <= dd[QB-1:0];
      lane_r[0][i].neg <= neg4_r[i];
    end
    dvs_r[0] <= {n4_r, 1'b0};
    dz_r[0]  <= zero4_r;
    dsc_r[0] <= sc4_r;
    dtr_r[0] <= tr4_r;
  end

  // advance the divider two bits a stage
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    always_ff @(posedge clk) begin : div_stage
      qstm_lane_t t;
      for (int i = 0; i < LANES; i++) begin
        t = lane_r[k-1][i];
        for (int s = 0; s < STEPS_PER_STAGE; s++) t = div_step(t, dvs_r[k-1]);
        lane_r[k][i] <= t;
      end
      dvs_r[k] <= dvs_r[k-1];
      dz_r[k]  <= dz_r[k-1];
      dsc_r[k] <= dsc_r[k-1];
      dtr_r[k] <= dtr_r[k-1];
    end
  end

  // apply sign, or drop to scaled identity for a zero quaternion
  always_ff @(posedge clk) begin : out_stage
    logic [OW-1:0] qv;
    for (int i = 0; i < LANES; i++) begin
      qv = OW'(lane_r[DIV_STAGES][i].lo);
      if (dz_r[DIV_STAGES]) begin
        if (i % 4 == 0) mo_r[i] <= OW'($signed({dsc_r[DIV_STAGES][i/3], 8'h00}));
        else            mo_r[i] <= '0;
      end else begin
        mo_r[i] <= lane_r[DIV_STAGES][i].neg ? $signed(-qv) : $signed(qv);
      end
    end
    zo_r <= dz_r[DIV_STAGES];
    to_r <= dtr_r[DIV_STAGES];
  end

  assign out_strobe = vo_r;
  assign out_m00 = mo_r[0];
  assign out_m01 = mo_r[1];
  assign out_m02 = mo_r[2];
  assign out_m10 = mo_r[3];
  assign out_m11 = mo_r[4];
  assign out_m12 = mo_r[5];
  assign out_m20 = mo_r[6];
  assign out_m21 = mo_r[7];
  assign out_m22 = mo_r[8];
  assign out_tx  = to_r[0];
  assign out_ty  = to_r[1];
  assign out_tz  = to_r[2];

  // a zero quaternion leaves every off-diagonal entry at zero
  a_zero_offdiag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && zo_r) |-> (out_m01 == 0 && out_m02 == 0 && out_m10 == 0 &&
                              out_m12 == 0 && out_m20 == 0 && out_m21 == 0))
    else $error("identity case produced nonzero off-diagonal entry");

  // a diagonal entry never exceeds 2^23 in magnitude
  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !zo_r) |-> (out_m00 <= 32'sd8388608 && out_m00 >= -32'sd8388608 &&
                               out_m11 <= 32'sd8388608 && out_m11 >= -32'sd8388608 &&
                               out_m22 <= 32'sd8388608 && out_m22 >= -32'sd8388608))
    else $error("matrix entry out of range");

  // no result leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");

  // divider remainder of lane 0 stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[DIV_STAGES] && !dz_r[DIV_STAGES]) |->
      (lane_r[DIV_STAGES][0].rem < dvs_r[DIV_STAGES]))
    else $error("divider remainder not reduced");

endmodule
`default_nettype wire
